// ===== hdl/oale_pkg.sv =====
// Shared constants and types for the ordered array list engine.
`timescale 1ns / 1ps
package oale_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int OPC_W  = 3;
	localparam int POS_W  = 11;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNTO_W = 11;

	// wide enough for position, count and count + 1
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam int IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = POS_W + VAL_W + CNTO_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [OPC_W-1:0] OP_INSERT    = 3'd0;
	localparam logic [OPC_W-1:0] OP_DELETE    = 3'd1;
	localparam logic [OPC_W-1:0] OP_OVERWRITE = 3'd2;
	localparam logic [OPC_W-1:0] OP_SEARCH    = 3'd3;
	localparam logic [OPC_W-1:0] OP_READ      = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_PUT,
		S_DEL,
		S_WR,
		S_RDW,
		S_SRCH,
		S_RESP
	} state_t;

endpackage

// ===== hdl/ordered_array_list_engine.sv =====
// Ordered array list engine: list store in one RAM, sequencer and result register.
//
// Input channel s_*: one item per request. s_tuser carries the opcode
// (insert, delete, overwrite, search, read); s_tdata carries the 1-based
// position and the value. Output channel m_*: exactly one item per request,
// m_tuser carries the status, m_tdata the found position, read value and
// live count after the request.
// The list lives in a single-port-write, single-port-read RAM of DEPTH words
// with registered read data; a sequencer walks it one entry per cycle.
// Steps from acceptance to result valid, with count c and position p:
//   rejected or unused opcode: straight to the result; overwrite: write at p; read: read at p;
//   insert: shift reads down from the top to p, then write the value;
//   delete: shift reads up from the gap at p;
//   search: walk from the first entry, stop at a hit at position k or after all c entries.
// The one-entry-per-cycle RAM walk sets the worst case, which grows with the count.
// A new item is taken only when the sequencer is idle, but that may happen
// while the previous result still waits in the output register; a stalled
// receiver holds the sequencer in its final state until the register frees.
// Reset empties the list (count zero) and drops any pending result; RAM
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module ordered_array_list_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [oale_pkg::IN_DATA_W-1:0]       s_tdata,  // position, value, zero pad
	input  logic [oale_pkg::OPC_W-1:0]           s_tuser,  // opcode
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [oale_pkg::OUT_DATA_W-1:0]      m_tdata,  // found_position, read_value, count, pad
	output logic [oale_pkg::STAT_W-1:0]          m_tuser   // status
);

	localparam int ADDR_W = oale_pkg::ADDR_W;
	localparam int CNT_W  = oale_pkg::CNT_W;
	localparam int CMP_W  = oale_pkg::CMP_W;
	localparam int POS_W  = oale_pkg::POS_W;
	localparam int VAL_W  = oale_pkg::VAL_W;
	localparam int OPC_W_L = oale_pkg::OPC_W;

	oale_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  base_q;
	logic signed [VAL_W-1:0] val_q;
	oale_pkg::status_t res_status_q, idle_status;
	logic [POS_W-1:0]  res_found_q;
	logic [VAL_W-1:0]  res_read_q;

	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              rd_vld_s1;
	logic [CNT_W-1:0]  rd_idx_s1;
	logic [VAL_W-1:0]  mem_rd_s1;
	logic [VAL_W-1:0]  mem [oale_pkg::DEPTH];

	logic              m_tvalid_q;
	logic [oale_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [oale_pkg::STAT_W-1:0]     m_tuser_q;

	logic              accept, out_load, out_free;
	logic              ins_issue, del_issue, srch_issue, srch_hit, del_done;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [VAL_W-1:0]  wr_data;

	logic [CMP_W-1:0]  pos_w, cnt_w;
	logic [OPC_W_L-1:0] in_op;
	logic signed [VAL_W-1:0] in_val;
	logic              cnt_full, ins_bad, pos_bad;

	assign in_op  = s_tuser;
	assign in_val = s_tdata[POS_W +: VAL_W];
	assign pos_w  = CMP_W'(s_tdata[POS_W-1:0]);
	assign cnt_w  = CMP_W'(count_q);

	assign cnt_full = (count_q == CNT_W'(oale_pkg::DEPTH));
	assign ins_bad  = (pos_w == '0) || (pos_w > cnt_w + CMP_W'(1));
	assign pos_bad  = (pos_w == '0) || (pos_w > cnt_w);

	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign ins_issue  = (state_q == oale_pkg::S_INS) && (idx_q > base_q);
	assign del_issue  = (state_q == oale_pkg::S_DEL) && (idx_q < count_q);
	assign del_done   = (state_q == oale_pkg::S_DEL) && !(idx_q < count_q);
	assign srch_issue = (state_q == oale_pkg::S_SRCH) && (idx_q < count_q);
	assign srch_hit   = (state_q == oale_pkg::S_SRCH) && rd_vld_s1 && (mem_rd_s1 == val_q);

	// sequencer: next state and RAM port control
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		out_load    = 1'b0;
		idle_status = oale_pkg::ST_OK;
		rd_en       = 1'b0;
		rd_addr     = ADDR_W'(pos_w - CMP_W'(1));
		wr_en       = 1'b0;
		wr_addr     = base_q[ADDR_W-1:0];
		wr_data     = val_q;
		unique case (state_q)
			oale_pkg::S_IDLE: begin
				s_tready = 1'b1;
				unique case (in_op)
					oale_pkg::OP_INSERT: begin
						priority if (cnt_full) begin
							idle_status = oale_pkg::ST_FULL;
						end else if (ins_bad) begin
							idle_status = oale_pkg::ST_RANGE;
						end else begin
							idle_status = oale_pkg::ST_OK;
						end
						if (idle_status == oale_pkg::ST_OK) begin
							if (s_tvalid) state_d = oale_pkg::S_INS;
						end else if (s_tvalid) begin
							state_d = oale_pkg::S_RESP;
						end
					end
					oale_pkg::OP_DELETE, oale_pkg::OP_OVERWRITE, oale_pkg::OP_READ: begin
						if (pos_bad) begin
							idle_status = oale_pkg::ST_RANGE;
							if (s_tvalid) state_d = oale_pkg::S_RESP;
						end else if (s_tvalid) begin
							unique case (in_op)
								oale_pkg::OP_DELETE:    state_d = oale_pkg::S_DEL;
								oale_pkg::OP_OVERWRITE: state_d = oale_pkg::S_WR;
								default: begin
									state_d = oale_pkg::S_RDW;
									rd_en   = 1'b1;
								end
							endcase
						end
					end
					oale_pkg::OP_SEARCH: begin
						idle_status = oale_pkg::ST_NOTFOUND;
						if (s_tvalid) begin
							state_d = (count_q == '0) ? oale_pkg::S_RESP : oale_pkg::S_SRCH;
						end
					end
					default: begin
						if (s_tvalid) state_d = oale_pkg::S_RESP;
					end
				endcase
			end
			oale_pkg::S_INS: begin
				// read one below, write it one up in the next cycle
				rd_en   = ins_issue;
				rd_addr = ADDR_W'(idx_q - CNT_W'(1));
				if (!ins_issue) state_d = oale_pkg::S_INS_PUT;
			end
			oale_pkg::S_INS_PUT: begin
				wr_en   = 1'b1;
				state_d = oale_pkg::S_RESP;
			end
			oale_pkg::S_DEL: begin
				rd_en   = del_issue;
				rd_addr = idx_q[ADDR_W-1:0];
				if (del_done) state_d = oale_pkg::S_RESP;
			end
			oale_pkg::S_WR: begin
				wr_en   = 1'b1;
				state_d = oale_pkg::S_RESP;
			end
			oale_pkg::S_RDW: begin
				state_d = oale_pkg::S_RESP;
			end
			oale_pkg::S_SRCH: begin
				rd_en   = srch_issue;
				rd_addr = idx_q[ADDR_W-1:0];
				if (srch_hit || !(idx_q < count_q)) state_d = oale_pkg::S_RESP;
			end
			oale_pkg::S_RESP: begin
				out_load = out_free;
				if (out_free) state_d = oale_pkg::S_IDLE;
			end
			default: state_d = oale_pkg::S_IDLE;
		endcase
		// shift write-back takes the port over the value write
		if (wr_pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = wr_addr_s1;
			wr_data = mem_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= oale_pkg::S_IDLE;
			count_q    <= '0;
			wr_pend_s1 <= 1'b0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_pend_s1 <= ins_issue || del_issue;
			rd_vld_s1  <= srch_issue;
			if (state_q == oale_pkg::S_INS_PUT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (del_done) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) mem_rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			oale_pkg::S_IDLE: begin
				if (accept) begin
					val_q        <= in_val;
					base_q       <= CNT_W'(pos_w - CMP_W'(1));
					res_status_q <= idle_status;
					res_found_q  <= '0;
					res_read_q   <= '0;
					priority if (in_op == oale_pkg::OP_INSERT) begin
						idx_q <= count_q;
					end else if (in_op == oale_pkg::OP_DELETE) begin
						idx_q <= CNT_W'(pos_w);
					end else begin
						idx_q <= '0;
					end
				end
			end
			oale_pkg::S_INS: begin
				if (ins_issue) begin
					idx_q      <= idx_q - CNT_W'(1);
					wr_addr_s1 <= idx_q[ADDR_W-1:0];
				end
			end
			oale_pkg::S_DEL: begin
				if (del_issue) begin
					idx_q      <= idx_q + CNT_W'(1);
					wr_addr_s1 <= ADDR_W'(idx_q - CNT_W'(1));
				end
			end
			oale_pkg::S_SRCH: begin
				if (srch_issue) begin
					idx_q     <= idx_q + CNT_W'(1);
					rd_idx_s1 <= idx_q;
				end
				if (srch_hit) begin
					res_status_q <= oale_pkg::ST_OK;
					res_found_q  <= POS_W'(rd_idx_s1 + CNT_W'(1));
				end
			end
			oale_pkg::S_RDW: begin
				res_read_q <= mem_rd_s1;
			end
			default: ;
		endcase
		if (out_load) begin
			m_tdata_q <= oale_pkg::OUT_DATA_W'({oale_pkg::CNTO_W'(count_q), res_read_q,
				res_found_q});
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(oale_pkg::DEPTH))
		else $error("live count beyond store depth");

	a_shift_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (state_q == oale_pkg::S_INS || state_q == oale_pkg::S_DEL))
		else $error("shift write-back outside insert or delete walk");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1)
			|| count_q == $past(count_q) - CNT_W'(1)))
		else $error("live count moved by more than one");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == oale_pkg::S_INS_PUT |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == oale_pkg::S_IDLE |-> !wr_pend_s1 && !rd_vld_s1)
		else $error("RAM walk still in flight while idle");

endmodule
